FILE: rtl/pnc_pkg.sv
// Shared types and constants for the PN preamble correlator.
package pnc_pkg;

  // Configuration register widths
  localparam int CHIP_W       = 64;
  localparam int CHIP_IDX_W   = 6;
  localparam int TAPS_REG_W   = 7;
  localparam int OS_REG_W     = 4;
  localparam int OS_EFF_W     = 5;
  localparam int ENERGY_W     = 36;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 64;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_CHIP_PATTERN     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_ORDER    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAPS_IN_USE      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERSAMPLE       = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_THRESHOLD = 8'd4;

  // Reset values
  localparam logic [TAPS_REG_W-1:0] TAPS_RESET = 7'd64;
  localparam logic [OS_REG_W-1:0]   OS_RESET   = 4'd1;

  // Settings seen by every cell during a correlation pass
  typedef struct packed {
    logic [CHIP_W-1:0]     chip;
    logic                  reverse;
    logic [TAPS_REG_W-1:0] taps_eff;
    logic [OS_EFF_W-1:0]   os_eff;
  } pnc_scan_cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SQUARE,
    ST_ENERGY,
    ST_FINISH
  } pnc_state_t;

endpackage

FILE: rtl/pn_preamble_correlator_core.sv
// Top level of the PN preamble correlator: config registers, cell chain, energy and output.
//
// Channel  Dir  Handshake              Beat contents
// in_      in   in_tvalid/in_tready    in_i, in_q
// out_     out  out_tvalid/out_tready  out_i, out_q, energy; detected on out_tuser
// cfg_     in   cfg_valid/cfg_ready    register index, write data
//
// From accept, the partial sum travels the MAX_TAPS cells one per clock; then the square,
// energy and output registers follow, the compare being made as the output register loads.
// The next item is accepted no earlier than the cycle after the result is loaded.
// Reset clears the sample line and loads the register defaults; no clearing pass is needed.
// A stalled result holds the output register; the sequencer waits only if a second result
// is ready before the first one is taken.
module pn_preamble_correlator_core
  import pnc_pkg::*;
#(
  parameter int MAX_TAPS       = 64,
  parameter int MAX_OVERSAMPLE = 8,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // input stream
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // in_tdata: in_i, in_q
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            in_tdata,
  // result stream
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // out_tdata: out_i, out_q, energy
  output logic [((2*SAMPLE_BITS+ENERGY_W+7)/8)*8-1:0]   out_tdata,
  // out_tuser: detected
  output logic [0:0]                                    out_tuser,
  // configuration writes
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]                        cfg_index,
  input  logic [CFG_DATA_W-1:0]                         cfg_data
);

  localparam int OUT_TDATA_W = ((2*SAMPLE_BITS+ENERGY_W+7)/8)*8;
  localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_TAPS) + 1;
  localparam int M_W         = $clog2(MAX_TAPS) + 1;
  localparam int SQ_W        = 2 * SUM_W;
  localparam int WIDE_W      = (SQ_W + 1 > ENERGY_W + 1) ? SQ_W + 1 : ENERGY_W + 1;
  localparam int CNT_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  // Configuration registers
  logic [CHIP_W-1:0]     chip_r;
  logic                  reverse_r;
  logic [TAPS_REG_W-1:0] taps_r;
  logic [OS_REG_W-1:0]   os_r;
  logic [ENERGY_W-1:0]   thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_r    <= '0;
      reverse_r <= 1'b0;
      taps_r    <= TAPS_RESET;
      os_r      <= OS_RESET;
      thr_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHIP_PATTERN:     chip_r    <= cfg_data;
        REG_REVERSE_ORDER:    reverse_r <= cfg_data[0];
        REG_TAPS_IN_USE:      taps_r    <= cfg_data[TAPS_REG_W-1:0];
        REG_OVERSAMPLE:       os_r      <= cfg_data[OS_REG_W-1:0];
        REG_ENERGY_THRESHOLD: thr_r     <= cfg_data[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp tap count and spacing into range
  pnc_scan_cfg_t scan_cfg;
  logic [OS_EFF_W-1:0] os_wide;

  assign os_wide = {1'b0, os_r};

  always_comb begin
    scan_cfg.chip    = chip_r;
    scan_cfg.reverse = reverse_r;
    if (taps_r == '0) begin
      scan_cfg.taps_eff = TAPS_REG_W'(1);
    end else if (taps_r > TAPS_REG_W'(MAX_TAPS)) begin
      scan_cfg.taps_eff = TAPS_REG_W'(MAX_TAPS);
    end else begin
      scan_cfg.taps_eff = taps_r;
    end
    if (os_wide == '0) begin
      scan_cfg.os_eff = OS_EFF_W'(1);
    end else if (os_wide > OS_EFF_W'(MAX_OVERSAMPLE)) begin
      scan_cfg.os_eff = OS_EFF_W'(MAX_OVERSAMPLE);
    end else begin
      scan_cfg.os_eff = os_wide;
    end
  end

  // Sequencer
  pnc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             square_en;
  logic             energy_en;
  logic             load_out;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_cnt_r == CNT_W'(MAX_TAPS - 1)) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_ENERGY;
      ST_ENERGY: state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    square_en = (state_r == ST_SQUARE);
    energy_en = (state_r == ST_ENERGY);
    load_out  = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  end

  assign accept       = in_tvalid && in_tready;
  assign scan_cnt_nxt = (state_r == ST_SCAN) ? scan_cnt_r + CNT_W'(1) : '0;

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Cell chain
  logic signed [SAMPLE_BITS-1:0] smp_i  [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] smp_q  [MAX_TAPS];
  logic signed [SUM_W-1:0]       wsum_i [MAX_TAPS];
  logic signed [SUM_W-1:0]       wsum_q [MAX_TAPS];
  logic [OS_EFF_W-1:0]           wphase [MAX_TAPS];
  logic [M_W-1:0]                wtap   [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] wold_i [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] wold_q [MAX_TAPS];

  logic signed [SAMPLE_BITS-1:0] in_i;
  logic signed [SAMPLE_BITS-1:0] in_q;

  assign in_i = in_tdata[SAMPLE_BITS-1:0];
  assign in_q = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      pnc_cell #(
        .DEPTH       (MAX_OVERSAMPLE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .M_W         (M_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept),
        .smp_i_in  (in_i),
        .smp_q_in  (in_q),
        .smp_i_out (smp_i[k]),
        .smp_q_out (smp_q[k]),
        .scan_cfg  (scan_cfg),
        .sum_i_in  ('0),
        .sum_q_in  ('0),
        .phase_in  ('0),
        .tap_in    ('0),
        .old_i_in  ('0),
        .old_q_in  ('0),
        .sum_i_out (wsum_i[k]),
        .sum_q_out (wsum_q[k]),
        .phase_out (wphase[k]),
        .tap_out   (wtap[k]),
        .old_i_out (wold_i[k]),
        .old_q_out (wold_q[k])
      );
    end else begin : g_body
      pnc_cell #(
        .DEPTH       (MAX_OVERSAMPLE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .M_W         (M_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept),
        .smp_i_in  (smp_i[k-1]),
        .smp_q_in  (smp_q[k-1]),
        .smp_i_out (smp_i[k]),
        .smp_q_out (smp_q[k]),
        .scan_cfg  (scan_cfg),
        .sum_i_in  (wsum_i[k-1]),
        .sum_q_in  (wsum_q[k-1]),
        .phase_in  (wphase[k-1]),
        .tap_in    (wtap[k-1]),
        .old_i_in  (wold_i[k-1]),
        .old_q_in  (wold_q[k-1]),
        .sum_i_out (wsum_i[k]),
        .sum_q_out (wsum_q[k]),
        .phase_out (wphase[k]),
        .tap_out   (wtap[k]),
        .old_i_out (wold_i[k]),
        .old_q_out (wold_q[k])
      );
    end
  end

  // Square the I and Q sums
  logic signed [SQ_W-1:0]        sq_i_r, sq_q_r;
  logic signed [SAMPLE_BITS-1:0] old_i_r, old_q_r;

  always_ff @(posedge clk) begin
    if (square_en) begin
      sq_i_r  <= SQ_W'(wsum_i[MAX_TAPS-1]) * SQ_W'(wsum_i[MAX_TAPS-1]);
      sq_q_r  <= SQ_W'(wsum_q[MAX_TAPS-1]) * SQ_W'(wsum_q[MAX_TAPS-1]);
      old_i_r <= wold_i[MAX_TAPS-1];
      old_q_r <= wold_q[MAX_TAPS-1];
    end
  end

  // Energy with saturation
  logic [WIDE_W-1:0]   e_wide;
  logic [ENERGY_W-1:0] energy_r;

  assign e_wide = WIDE_W'($unsigned(sq_i_r)) + WIDE_W'($unsigned(sq_q_r));

  always_ff @(posedge clk) begin
    if (energy_en) begin
      if (e_wide > WIDE_W'(ENERGY_MAX)) begin
        energy_r <= ENERGY_MAX;
      end else begin
        energy_r <= e_wide[ENERGY_W-1:0];
      end
    end
  end

  // Output register
  logic [SAMPLE_BITS-1:0] out_i_r, out_q_r;
  logic [ENERGY_W-1:0]    out_energy_r;
  logic                   out_det_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_i_r      <= old_i_r;
      out_q_r      <= old_q_r;
      out_energy_r <= energy_r;
      out_det_r    <= (energy_r > thr_r);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_TDATA_W'({out_energy_r, out_q_r, out_i_r});
  assign out_tuser[0] = out_det_r;

endmodule

FILE: rtl/pnc_cell.sv
// One correlator cell: a segment of the sample line plus one stage of the partial-sum wave.
module pnc_cell
  import pnc_pkg::*;
#(
  parameter int DEPTH       = 8,
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_W       = 19,
  parameter int M_W         = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample line
  input  logic                          shift_en,
  input  logic signed [SAMPLE_BITS-1:0] smp_i_in,
  input  logic signed [SAMPLE_BITS-1:0] smp_q_in,
  output logic signed [SAMPLE_BITS-1:0] smp_i_out,
  output logic signed [SAMPLE_BITS-1:0] smp_q_out,
  // correlation settings
  input  pnc_scan_cfg_t                 scan_cfg,
  // wave from the previous cell
  input  logic signed [SUM_W-1:0]       sum_i_in,
  input  logic signed [SUM_W-1:0]       sum_q_in,
  input  logic [OS_EFF_W-1:0]           phase_in,
  input  logic [M_W-1:0]                tap_in,
  input  logic signed [SAMPLE_BITS-1:0] old_i_in,
  input  logic signed [SAMPLE_BITS-1:0] old_q_in,
  // wave to the next cell
  output logic signed [SUM_W-1:0]       sum_i_out,
  output logic signed [SUM_W-1:0]       sum_q_out,
  output logic [OS_EFF_W-1:0]           phase_out,
  output logic [M_W-1:0]                tap_out,
  output logic signed [SAMPLE_BITS-1:0] old_i_out,
  output logic signed [SAMPLE_BITS-1:0] old_q_out
);

  // seg[p] holds the sample of age (cell * DEPTH + p)
  logic signed [SAMPLE_BITS-1:0] seg_i_r [DEPTH];
  logic signed [SAMPLE_BITS-1:0] seg_q_r [DEPTH];

  logic signed [SUM_W-1:0]       sum_i_r, sum_i_nxt;
  logic signed [SUM_W-1:0]       sum_q_r, sum_q_nxt;
  logic [OS_EFF_W-1:0]           phase_r, phase_nxt;
  logic [M_W-1:0]                tap_r, tap_nxt;
  logic signed [SAMPLE_BITS-1:0] old_i_r, old_i_nxt;
  logic signed [SAMPLE_BITS-1:0] old_q_r, old_q_nxt;

  // Segment shift; the line reads as zeros until filled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_i_r <= '{default: '0};
      seg_q_r <= '{default: '0};
    end else if (shift_en) begin
      seg_i_r[0] <= smp_i_in;
      seg_q_r[0] <= smp_q_in;
      for (int p = 1; p < DEPTH; p++) begin
        seg_i_r[p] <= seg_i_r[p-1];
        seg_q_r[p] <= seg_q_r[p-1];
      end
    end
  end

  assign smp_i_out = seg_i_r[DEPTH-1];
  assign smp_q_out = seg_q_r[DEPTH-1];

  // Walk the segment by age: phase marks tap positions, tap counts taps seen
  always_comb begin
    logic [TAPS_REG_W-1:0] tap_ext;
    logic [TAPS_REG_W-1:0] coef_idx;
    logic                  plus;
    sum_i_nxt = sum_i_in;
    sum_q_nxt = sum_q_in;
    phase_nxt = phase_in;
    tap_nxt   = tap_in;
    old_i_nxt = old_i_in;
    old_q_nxt = old_q_in;
    tap_ext   = '0;
    coef_idx  = '0;
    plus      = 1'b0;
    for (int p = 0; p < DEPTH; p++) begin
      if (phase_nxt == scan_cfg.os_eff - OS_EFF_W'(1)) begin
        tap_ext = TAPS_REG_W'(tap_nxt);
        if (tap_ext < scan_cfg.taps_eff) begin
          coef_idx = scan_cfg.reverse ? (scan_cfg.taps_eff - TAPS_REG_W'(1) - tap_ext)
                                      : tap_ext;
          plus = scan_cfg.chip[coef_idx[CHIP_IDX_W-1:0]];
          if (plus) begin
            sum_i_nxt = sum_i_nxt + SUM_W'(seg_i_r[p]);
            sum_q_nxt = sum_q_nxt + SUM_W'(seg_q_r[p]);
          end else begin
            sum_i_nxt = sum_i_nxt - SUM_W'(seg_i_r[p]);
            sum_q_nxt = sum_q_nxt - SUM_W'(seg_q_r[p]);
          end
          // last tap is the oldest sample of the window
          if (tap_ext == scan_cfg.taps_eff - TAPS_REG_W'(1)) begin
            old_i_nxt = seg_i_r[p];
            old_q_nxt = seg_q_r[p];
          end
        end
        phase_nxt = '0;
        if (tap_nxt != '1) begin
          tap_nxt = tap_nxt + M_W'(1);
        end
      end else begin
        phase_nxt = phase_nxt + OS_EFF_W'(1);
      end
    end
  end

  // Wave stage, handed on every cycle
  always_ff @(posedge clk) begin
    sum_i_r <= sum_i_nxt;
    sum_q_r <= sum_q_nxt;
    phase_r <= phase_nxt;
    tap_r   <= tap_nxt;
    old_i_r <= old_i_nxt;
    old_q_r <= old_q_nxt;
  end

  assign sum_i_out = sum_i_r;
  assign sum_q_out = sum_q_r;
  assign phase_out = phase_r;
  assign tap_out   = tap_r;
  assign old_i_out = old_i_r;
  assign old_q_out = old_q_r;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the PN preamble correlator core: queue-fed driver, monitor, predictor.
`timescale 1ns / 100ps

module testbench
  import pnc_pkg::*;
();

  localparam int SAMPLE_BITS    = 12;
  localparam int MAX_TAPS       = 64;
  localparam int MAX_OVERSAMPLE = 8;
  localparam int LINE_DEPTH     = MAX_TAPS * MAX_OVERSAMPLE;
  localparam int IN_W           = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int OUT_W          = ((2*SAMPLE_BITS+ENERGY_W+7)/8)*8;
  localparam int Q_LO           = SAMPLE_BITS;
  localparam int E_LO           = 2*SAMPLE_BITS;
  localparam int RANDOM_ITEMS   = 800;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 2*(MAX_TAPS+4);

  // Indexes that map to no register; writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP   = 8'hFF;

  // Packed so that i lands in the low bits of in_tdata
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] q;
    logic signed [SAMPLE_BITS-1:0] i;
  } iq_sample_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] i;
    logic signed [SAMPLE_BITS-1:0] q;
    logic [ENERGY_W-1:0]           energy;
    logic                          detected;
  } corr_result_t;

  typedef struct {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_W-1:0]       out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  iq_sample_t   pending_samples[$];
  corr_result_t expected_results[$];
  reg_write_t   pending_writes[$];

  int errors        = 0;
  int cycles        = 0;
  int queued_items  = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 88;

  // Predictor copy of the delay line and the registers
  logic signed [SAMPLE_BITS-1:0] line_i [LINE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] line_q [LINE_DEPTH];
  int                    line_wr;
  logic [CHIP_W-1:0]     chip_reg;
  logic                  rev_reg;
  logic [TAPS_REG_W-1:0] taps_reg;
  logic [OS_REG_W-1:0]   os_reg;
  logic [ENERGY_W-1:0]   thresh_reg;

  pn_preamble_correlator_core #(
    .MAX_TAPS      (MAX_TAPS),
    .MAX_OVERSAMPLE(MAX_OVERSAMPLE),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int taps_eff(int t);
    return (t < 1) ? 1 : ((t > MAX_TAPS) ? MAX_TAPS : t);
  endfunction

  function automatic int os_eff(int o);
    return (o < 1) ? 1 : ((o > MAX_OVERSAMPLE) ? MAX_OVERSAMPLE : o);
  endfunction

  function automatic int clip_sample(int v);
    return (v > 2047) ? 2047 : ((v < -2048) ? -2048 : v);
  endfunction

  // Shift one sample into the line and correlate the window against the chips
  function automatic corr_result_t correlate_sample(iq_sample_t s);
    corr_result_t r;
    int taps, os, span, pos, cidx;
    longint si, sq;
    longint unsigned e;
    taps = taps_eff(int'(taps_reg));
    os   = os_eff(int'(os_reg));
    span = taps * os;
    si   = 0;
    sq   = 0;
    line_wr = (line_wr + 1) % LINE_DEPTH;
    line_i[line_wr] = s.i;
    line_q[line_wr] = s.q;
    for (int j = 0; j < taps; j++) begin
      pos  = (line_wr + LINE_DEPTH - (span - 1 - j*os)) % LINE_DEPTH;
      cidx = rev_reg ? j : (taps - 1 - j);
      if (chip_reg[cidx]) begin
        si += line_i[pos];
        sq += line_q[pos];
      end else begin
        si -= line_i[pos];
        sq -= line_q[pos];
      end
    end
    e = si*si + sq*sq;
    if (e > ENERGY_MAX) e = ENERGY_MAX;
    pos = (line_wr + LINE_DEPTH - (span - 1)) % LINE_DEPTH;
    r.i        = line_i[pos];
    r.q        = line_q[pos];
    r.energy   = e[ENERGY_W-1:0];
    r.detected = (r.energy > thresh_reg);
    return r;
  endfunction

  function automatic void apply_reg(reg_write_t w);
    case (w.index)
      REG_CHIP_PATTERN:     chip_reg   = w.data[CHIP_W-1:0];
      REG_REVERSE_ORDER:    rev_reg    = w.data[0];
      REG_TAPS_IN_USE:      taps_reg   = w.data[TAPS_REG_W-1:0];
      REG_OVERSAMPLE:       os_reg     = w.data[OS_REG_W-1:0];
      REG_ENERGY_THRESHOLD: thresh_reg = w.data[ENERGY_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic compare_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // Queue a register write; junk fills the bits above the register width
  task automatic queue_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit junk);
    int w;
    logic [CFG_DATA_W-1:0] d;
    case (idx)
      REG_REVERSE_ORDER:    w = 1;
      REG_TAPS_IN_USE:      w = TAPS_REG_W;
      REG_OVERSAMPLE:       w = OS_REG_W;
      REG_ENERGY_THRESHOLD: w = ENERGY_W;
      default:              w = CFG_DATA_W;
    endcase
    d = val;
    if (junk && w < CFG_DATA_W) d = val | ({$urandom, $urandom} << w);
    pending_writes.push_back('{idx, d});
  endtask

  task automatic push_sample(int i, int q);
    iq_sample_t s;
    s.i = i[SAMPLE_BITS-1:0];
    s.q = q[SAMPLE_BITS-1:0];
    pending_samples.push_back(s);
    queued_items++;
  endtask

  task automatic push_noise(int n);
    for (int k = 0; k < n; k++) begin
      push_sample(int'($urandom_range(4095)), int'($urandom_range(4095)));
    end
  endtask

  // Chips spread over os samples each, oldest tap first; keep < taps cuts the burst short
  task automatic push_preamble(int taps, int os, logic [CHIP_W-1:0] chip, bit rev,
                               int ai, int aq, int nz, int keep);
    int c;
    for (int j = 0; j < keep; j++) begin
      c = chip[rev ? j : (taps - 1 - j)] ? 1 : -1;
      for (int k = 0; k < os; k++) begin
        push_sample(clip_sample(c*ai + int'($urandom_range(2*nz)) - nz),
                    clip_sample(c*aq + int'($urandom_range(2*nz)) - nz));
      end
    end
  endtask

  // Block until every queued write and item is through and every result has come back
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_tvalid || expected_results.size() != 0 ||
           pending_writes.size() != 0 || cfg_valid)
      @(posedge clk);
  endtask

  // Input driver: beat held until accepted, prediction taken at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(correlate_sample(pending_samples.pop_front()));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'(pending_samples[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Register write driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(pending_writes.pop_front());
      if (!cfg_valid || cfg_ready) begin
        if (pending_writes.size() != 0) begin
          cfg_valid <= 1'b1;
          cfg_index <= pending_writes[0].index;
          cfg_data  <= pending_writes[0].data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    corr_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation pending");
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("out_i", want.i, $signed(out_tdata[Q_LO-1:0]));
          compare_field("out_q", want.q, $signed(out_tdata[E_LO-1:Q_LO]));
          compare_field("energy", want.energy, out_tdata[E_LO+ENERGY_W-1:E_LO]);
          compare_field("detected", want.detected, out_tuser[0]);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int base, seg, prog, r, t_raw, o_raw, te, oe, ai, aq, nz, npre, keep;
    logic [CHIP_W-1:0] chip;
    logic [ENERGY_W-1:0] thr;
    bit rev, junk;
    longint peak;

    for (int k = 0; k < LINE_DEPTH; k++) begin
      line_i[k] = '0;
      line_q[k] = '0;
    end
    line_wr    = 0;
    chip_reg   = '0;
    rev_reg    = 1'b0;
    taps_reg   = TAPS_RESET;
    os_reg     = OS_RESET;
    thresh_reg = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults, field extremes; warm-up reads zeros from the unfilled line
    push_sample(2047, 2047);
    push_sample(-2048, -2048);
    push_sample(2047, -2048);
    push_sample(-2048, 2047);
    push_sample(0, 0);

    // Zero taps and zero spacing act as one; energy equal to the threshold is no hit
    wait_idle();
    queue_reg(REG_TAPS_IN_USE, 0, 0);
    queue_reg(REG_OVERSAMPLE, 0, 0);
    queue_reg(REG_CHIP_PATTERN, 0, 0);
    queue_reg(REG_REVERSE_ORDER, 1, 0);
    queue_reg(REG_ENERGY_THRESHOLD, 64'd8388608, 0);
    wait_idle();
    push_sample(-2048, -2048);
    push_sample(-2048, -2048);
    wait_idle();
    queue_reg(REG_ENERGY_THRESHOLD, 64'd8388607, 0);
    wait_idle();
    push_sample(-2048, -2048);
    push_sample(2047, 2047);

    // Over-range tap count and spacing clamp to the maximum; line is read, not cleared
    wait_idle();
    queue_reg(REG_TAPS_IN_USE, 127, 0);
    queue_reg(REG_OVERSAMPLE, 15, 0);
    queue_reg(REG_CHIP_PATTERN, {$urandom, $urandom}, 0);
    queue_reg(REG_REVERSE_ORDER, 0, 0);
    wait_idle();
    push_noise(2);
    push_sample(2047, -2048);

    // Writes to unmapped indexes change nothing
    wait_idle();
    queue_reg(REG_SPARE, {$urandom, $urandom}, 0);
    queue_reg(REG_TOP, {$urandom, $urandom}, 0);
    wait_idle();
    push_noise(2);

    // Largest in-range spacing, top threshold never reached
    wait_idle();
    queue_reg(REG_TAPS_IN_USE, 2, 0);
    queue_reg(REG_OVERSAMPLE, MAX_OVERSAMPLE, 0);
    queue_reg(REG_CHIP_PATTERN, {32{2'b01}}, 0);
    queue_reg(REG_ENERGY_THRESHOLD, ENERGY_MAX, 0);
    wait_idle();
    push_noise(3);

    // Random segments: one setting each, preamble bursts in noise
    base = queued_items;
    seg  = 0;
    while (queued_items - base < RANDOM_ITEMS) begin
      prog = queued_items - base;
      if (prog < RANDOM_ITEMS/3) begin
        send_idle_pct = 37;
        recv_idle_pct = 88;
      end else if (prog < 2*RANDOM_ITEMS/3) begin
        send_idle_pct = 88;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (seg < 2) begin
        // Full-scale coherent burst: energy peaks at 2^35, just above then at the threshold
        t_raw = MAX_TAPS;
        o_raw = 1;
        chip  = '1;
        rev   = $urandom_range(1);
        ai    = -2048;
        aq    = -2048;
        nz    = 0;
        thr   = (seg == 0) ? 36'h7_FFFF_FFFF : 36'h8_0000_0000;
        junk  = 0;
      end else begin
        r = $urandom_range(99);
        if (r < 70)      t_raw = $urandom_range(1, 16);
        else if (r < 85) t_raw = $urandom_range(17, 64);
        else if (r < 95) t_raw = $urandom_range(1) ? 0 : $urandom_range(65, 127);
        else             t_raw = MAX_TAPS;
        r = $urandom_range(99);
        if (r < 70)      o_raw = $urandom_range(1, 3);
        else if (r < 90) o_raw = $urandom_range(4, MAX_OVERSAMPLE);
        else             o_raw = $urandom_range(1) ? 0 : $urandom_range(9, 15);
        r = $urandom_range(9);
        chip = (r == 0) ? '0 : ((r == 1) ? '1 : {$urandom, $urandom});
        rev  = $urandom_range(1);
        ai   = int'($urandom_range(4095)) - 2048;
        aq   = int'($urandom_range(4095)) - 2048;
        nz   = $urandom_range(0, 300);
        peak = longint'(taps_eff(t_raw)) * taps_eff(t_raw) *
               (longint'(ai)*ai + longint'(aq)*aq);
        r = $urandom_range(99);
        if (r < 60)      thr = ENERGY_W'(peak/2 + $urandom_range(1000));
        else if (r < 80) thr = ENERGY_W'({$urandom, $urandom});
        else             thr = '0;
        junk = ($urandom_range(3) == 0);
      end
      te = taps_eff(t_raw);
      oe = os_eff(o_raw);

      wait_idle();
      queue_reg(REG_CHIP_PATTERN, chip, junk);
      queue_reg(REG_REVERSE_ORDER, rev, junk);
      queue_reg(REG_TAPS_IN_USE, t_raw, junk);
      queue_reg(REG_OVERSAMPLE, o_raw, junk);
      queue_reg(REG_ENERGY_THRESHOLD, thr, junk);
      wait_idle();

      push_noise($urandom_range(0, 8));
      npre = (seg < 2) ? 1 : $urandom_range(1, 2);
      for (int p = 0; p < npre; p++) begin
        keep = ($urandom_range(4) == 0) ? $urandom_range(1, te) : te;
        push_preamble(te, oe, chip, rev, ai, aq, nz, keep);
        push_noise($urandom_range(0, 6));
      end
      seg++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: pn_preamble_correlator_core.f
rtl/pnc_pkg.sv
rtl/pnc_cell.sv
rtl/pn_preamble_correlator_core.sv
tb/testbench.sv
